/* sv/mcbs_pkg.sv */
// Package for the multi-channel blink sequencer: sizes, request codes,
// the per-channel memory entry and the state machine type. No dependencies.
`default_nettype none

package mcbs_pkg;

    localparam int CHANNELS   = 16;
    localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TIME_BITS  = 16;
    localparam int CLOCK_BITS = 32;
    localparam int COUNT_BITS = 16;
    localparam int LAMP_BITS  = 16;

    // Request codes carried on the op field.
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    // One channel's stored pattern and progress.
    typedef struct packed {
        logic [TIME_BITS-1:0]  on_ticks;
        logic [TIME_BITS:0]    period_ticks;
        logic [COUNT_BITS-1:0] repeat_limit;
        logic [CLOCK_BITS-1:0] period_start;
        logic [COUNT_BITS-1:0] periods_done;
    } t_chan_entry;

    // Outcome of visiting one channel on a tick.
    typedef struct packed {
        t_chan_entry entry;
        logic        drive;
        logic        write_en;
    } t_visit_res;

endpackage

`default_nettype wire

/* sv/multi_channel_blink_sequencer.sv */
// Top level of the multi-channel blink sequencer: channel memory, tick sweep
// and result register. Depends on mcbs_pkg and mcbs_visit.
`default_nettype none

// Drives sixteen on/off outputs with blink patterns. Present a request with
// start high while busy is low. A pattern request (op = 0) loads one channel's
// on time, off time and repeat count and restarts its period; busy stays
// low, so a new request may follow at once. A tick request (op = 1)
// advances the 32-bit time counter and then sweeps the channel memory one
// entry per cycle through its single read port (read, update, write back);
// busy stays high until the last entry is done. Every request
// produces exactly one result: o_valid pulses for one cycle with the drive
// vector and the mask of drives that changed. The receiver cannot stall, so
// capture the result in the cycle o_valid is high. Reset needs no clearing
// pass: per-entry valid bits make unloaded channels read as idle.
module multi_channel_blink_sequencer import mcbs_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_op,
    input  wire logic [3:0]            i_channel,
    input  wire logic [15:0]           i_on_time,
    input  wire logic [15:0]           i_off_time,
    input  wire logic [15:0]           i_repeat_count,
    output logic                       o_valid,
    output logic [LAMP_BITS-1:0]       o_lamp_states,
    output logic [LAMP_BITS-1:0]       o_changed_mask
);

    // Channel memory: one synchronous read port, one write port.
    t_chan_entry mem [CHANNELS];

    t_state                r_state, n_state;
    logic [CLOCK_BITS-1:0] r_time_now;
    logic [CHANNELS-1:0]   r_drive, n_drive;
    logic [CHANNELS-1:0]   r_entry_valid;
    logic [CHANNELS-1:0]   r_before;
    logic [CH_BITS-1:0]    r_issue;
    logic                  r_issuing;
    logic                  r_proc_valid;
    logic [CH_BITS-1:0]    r_proc_idx;
    t_chan_entry           r_rd_entry;
    logic                  r_rd_valid;
    logic                  r_out_valid;
    logic [LAMP_BITS-1:0]  r_lamp;
    logic [LAMP_BITS-1:0]  r_changed;

    logic                  accept;
    logic                  pattern_req;
    logic                  tick_req;
    logic                  sweep_done;
    t_chan_entry           load_entry;
    t_visit_res            visit;

    assign accept      = start && !busy;
    assign pattern_req = accept && (i_op == OP_PATTERN);
    assign tick_req    = accept && (i_op == OP_TICK);
    assign sweep_done  = r_proc_valid && (r_proc_idx == CH_BITS'(CHANNELS - 1));

    // Pattern loaded by a pattern request; on plus off cannot overflow.
    always_comb begin
        load_entry.on_ticks     = TIME_BITS'(i_on_time);
        load_entry.period_ticks = (TIME_BITS+1)'(TIME_BITS'(i_on_time))
                                + (TIME_BITS+1)'(TIME_BITS'(i_off_time));
        load_entry.repeat_limit = i_repeat_count;
        load_entry.period_start = r_time_now;
        load_entry.periods_done = '0;
    end

    mcbs_visit u_visit (
        .i_entry       (r_rd_entry),
        .i_entry_valid (r_rd_valid),
        .i_time_now    (r_time_now),
        .i_drive       (r_drive[r_proc_idx]),
        .o_res         (visit)
    );

    // Next state and next drive vector.
    always_comb begin
        n_state = r_state;
        n_drive = r_drive;
        case (r_state)
            ST_IDLE: begin
                if (tick_req) begin
                    n_state = ST_SWEEP;
                end
                // zero on time switches the channel off at once
                if (pattern_req && (i_on_time == '0)) begin
                    n_drive[i_channel] = 1'b0;
                end
            end
            ST_SWEEP: begin
                if (r_proc_valid) begin
                    n_drive[r_proc_idx] = visit.drive;
                end
                if (sweep_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control: time counter, drives, valid bits, sweep counters, result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_now    <= '0;
            r_drive       <= '0;
            r_entry_valid <= '0;
            r_issue       <= '0;
            r_issuing     <= 1'b0;
            r_proc_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_drive      <= n_drive;
            r_out_valid  <= pattern_req || sweep_done;
            r_proc_valid <= r_issuing;
            if (pattern_req) begin
                r_entry_valid[i_channel] <= 1'b1;
            end
            if (tick_req) begin
                r_time_now <= r_time_now + CLOCK_BITS'(1);
                r_issue    <= '0;
                r_issuing  <= 1'b1;
            end else if (r_issuing) begin
                // stop issuing after the last entry
                if (r_issue == CH_BITS'(CHANNELS - 1)) begin
                    r_issuing <= 1'b0;
                end else begin
                    r_issue <= r_issue + CH_BITS'(1);
                end
            end
        end
    end

    // Memory and datapath registers. The read of entry c+1 and the write back
    // of entry c fall in the same cycle, so the two never collide.
    always_ff @(posedge i_clk) begin
        if (pattern_req) begin
            mem[i_channel] <= load_entry;
        end else if (r_proc_valid && visit.write_en) begin
            mem[r_proc_idx] <= visit.entry;
        end
        r_rd_entry <= mem[r_issue];
        r_rd_valid <= r_entry_valid[r_issue];
        r_proc_idx <= r_issue;
        if (accept) begin
            r_before <= r_drive;
        end
    end

    // Result register: drives after the request and the drives that moved.
    always_ff @(posedge i_clk) begin
        if (pattern_req) begin
            r_lamp    <= LAMP_BITS'(n_drive);
            r_changed <= LAMP_BITS'(n_drive ^ r_drive);
        end else if (sweep_done) begin
            r_lamp    <= LAMP_BITS'(n_drive);
            r_changed <= LAMP_BITS'(n_drive ^ r_before);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_lamp_states  = r_lamp;
    assign o_changed_mask = r_changed;

endmodule

`default_nettype wire

/* sv/mcbs_visit.sv */
// Per-channel tick update: phase check, period restart and repeat counting.
// Depends on mcbs_pkg.
`default_nettype none

module mcbs_visit import mcbs_pkg::*; (
    input  wire t_chan_entry           i_entry,
    input  wire logic                  i_entry_valid,
    input  wire logic [CLOCK_BITS-1:0] i_time_now,
    input  wire logic                  i_drive,
    output t_visit_res                 o_res
);

    logic [CLOCK_BITS-1:0] elapsed;
    logic [COUNT_BITS-1:0] done_inc;

    always_comb begin
        elapsed  = i_time_now - i_entry.period_start;
        done_inc = i_entry.periods_done + COUNT_BITS'(1);
        o_res          = '0;
        o_res.entry    = i_entry;
        o_res.drive    = i_drive;
        o_res.write_en = 1'b0;
        // skip idle channels and entries never loaded
        if (i_entry_valid && (i_entry.on_ticks != '0)) begin
            if (elapsed < CLOCK_BITS'(i_entry.on_ticks)) begin
                o_res.drive = 1'b1;
            end else if (elapsed < CLOCK_BITS'(i_entry.period_ticks)) begin
                o_res.drive = 1'b0;
            end else begin
                // period end: restart, count repeats, hold the drive; the last repeat switches it off
                o_res.write_en           = 1'b1;
                o_res.entry.period_start = i_time_now;
                if (i_entry.repeat_limit != '0) begin
                    o_res.entry.periods_done = done_inc;
                    if (done_inc >= i_entry.repeat_limit) begin
                        o_res.entry.on_ticks = '0;
                        o_res.drive          = 1'b0;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire
